[sv/cpct_pkg.sv]
// Package for the collider pair contact tracker.
// Field widths, event codes, state encoding and the times-50 helper.
// No dependencies.
`default_nettype none

package cpct_pkg;

    localparam int ID_BITS_DEF = 5;
    localparam int ID_W        = 5;
    localparam int XY_W        = 24;
    localparam int SZ_W        = 16;
    localparam int M50_W       = 25;
    localparam int DX_W        = 26;
    localparam int PROD_W      = 2 * DX_W;
    localparam int S_TDATA_W   = 176;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;

    localparam logic KIND_CIRCLE = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_event;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DX,
        S_DY,
        S_RECT,
        S_SQX,
        S_SQY,
        S_SQR,
        S_CMP,
        S_DONE
    } t_state;

    // x * 50 as shifts and adds
    function automatic logic signed [M50_W-1:0] mul50(input logic signed [SZ_W+1:0] a);
        logic signed [M50_W-1:0] v;
        v = M50_W'(a);
        return (v <<< 5) + (v <<< 4) + (v <<< 1);
    endfunction

endpackage

`default_nettype wire

[sv/cpct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cpct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/collider_pair_contact_tracker_top.sv]
// Collider pair contact tracker: shape test plus per-pair touching bitmap.
// Depends on cpct_pkg and cpct_ram.
// The shared multiplier and the sequencer take one item at a time.
// Reset: synchronous; afterwards the bitmap is cleared one entry per cycle,
// all 2**(2*ID_BITS) entries (1024 by default), with o_s_tready low.
`default_nettype none

module collider_pair_contact_tracker_top
    import cpct_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // left_id, right_id, left_x, left_y, left_w, left_h,
    // right_x, right_y, right_w, right_h, zero pad
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // left_kind, right_kind
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // contact_event[1:0], overlapping, zero pad
    output logic      [M_TDATA_W-1:0] o_m_tdata
);

    localparam int PAIR_AW    = 2 * ID_BITS;
    localparam int PAIR_DEPTH = 1 << PAIR_AW;

    t_state r_state, n_state;
    logic [PAIR_AW-1:0] r_clr, n_clr;
    logic r_out_valid, n_out_valid;

    logic [ID_W-1:0] r_lid, r_rid;
    logic r_lk, r_rk;
    logic signed [XY_W-1:0] r_lx, r_ly, r_rx, r_ry;
    logic [SZ_W-1:0] r_lw, r_lh, r_rw, r_rh;
    logic signed [DX_W-1:0] r_dx, r_dy, r_rsx, r_rsy;
    logic signed [DX_W-1:0] n_dx, n_dy, n_rsx, n_rsy;
    logic [PROD_W-1:0] r_prod, r_acc;
    logic r_hit, n_hit;
    t_event r_event, n_event;
    logic r_overlap;

    logic signed [DX_W-1:0] mul_a, abs_dx, abs_dy, dpos;
    logic signed [PROD_W-1:0] mul_p;
    logic circ, same, was, out_load;
    logic [SZ_W-1:0] pa_w, pa_h, pb_w, pb_h;
    logic signed [XY_W-1:0] pa_x, pb_x;
    logic [ID_BITS-1:0] lid_t, rid_t;
    logic [PAIR_AW-1:0] idx, ram_waddr;
    logic ram_we, ram_wdata, ram_rdata;

    assign lid_t = ID_BITS'(r_lid);
    assign rid_t = ID_BITS'(r_rid);
    assign idx   = {lid_t, rid_t};
    assign same  = (lid_t == rid_t);
    assign circ  = (r_lk == KIND_CIRCLE) && (r_rk == KIND_CIRCLE);
    assign was   = ram_rdata;

    cpct_ram #(
        .WIDTH (1),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (idx),
        .o_rdata (ram_rdata)
    );

    // shared axis unit: same adder serves x in S_DX, y in S_DY
    always_comb begin
        if (r_state == S_DY) begin
            pa_x = r_ly; pb_x = r_ry; pa_w = r_lh; pb_w = r_rh;
        end else begin
            pa_x = r_lx; pb_x = r_rx; pa_w = r_lw; pb_w = r_rw;
        end
        pa_h = pa_w;
        pb_h = pb_w;
        dpos = DX_W'(pa_x) - DX_W'(pb_x);
        if (circ) begin
            dpos = dpos + DX_W'(mul50($signed({2'b00, pa_h}) - $signed({2'b00, pb_h})));
        end
    end

    assign abs_dx = r_dx[DX_W-1] ? -r_dx : r_dx;
    assign abs_dy = r_dy[DX_W-1] ? -r_dy : r_dy;

    // shared multiplier
    always_comb begin
        case (r_state)
            S_SQX:   mul_a = r_dx;
            S_SQY:   mul_a = r_dy;
            default: mul_a = r_rsx;
        endcase
    end
    assign mul_p = mul_a * mul_a;

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_rsx       = r_rsx;
        n_rsy       = r_rsy;
        n_hit       = r_hit;
        n_event     = EV_NONE;
        o_s_tready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx;
        ram_wdata   = r_hit;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (same) begin
            n_event = EV_NONE;
        end else if (r_hit) begin
            n_event = was ? EV_STAY : EV_ENTER;
        end else if (was) begin
            n_event = EV_EXIT;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 1'b0;
                n_clr     = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = S_DX;
                end
            end
            S_DX: begin
                n_dx    = dpos;
                n_rsx   = DX_W'(mul50($signed({2'b00, r_lw}) + $signed({2'b00, r_rw})));
                n_state = S_DY;
            end
            S_DY: begin
                n_dy  = dpos;
                n_rsy = DX_W'(mul50($signed({2'b00, r_lh}) + $signed({2'b00, r_rh})));
                if (r_lk != r_rk) begin
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end else if (circ) begin
                    n_state = S_SQX;
                end else begin
                    n_state = S_RECT;
                end
            end
            S_RECT: begin
                n_hit   = (abs_dx < r_rsx) && (abs_dy < r_rsy);
                n_state = S_DONE;
            end
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SQR;
            S_SQR:   n_state = S_CMP;
            S_CMP: begin
                n_hit   = (r_acc <= r_prod);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    ram_we      = !same;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_lid <= i_s_tdata[4:0];
            r_rid <= i_s_tdata[9:5];
            r_lx  <= i_s_tdata[33:10];
            r_ly  <= i_s_tdata[57:34];
            r_lw  <= i_s_tdata[73:58];
            r_lh  <= i_s_tdata[89:74];
            r_rx  <= i_s_tdata[113:90];
            r_ry  <= i_s_tdata[137:114];
            r_rw  <= i_s_tdata[153:138];
            r_rh  <= i_s_tdata[169:154];
            r_lk  <= i_s_tuser[0];
            r_rk  <= i_s_tuser[1];
        end
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_rsx <= n_rsx;
        r_rsy <= n_rsy;
        r_hit <= n_hit;
        r_prod <= PROD_W'(mul_p);
        if (r_state == S_SQY) begin
            r_acc <= r_prod;
        end else if (r_state == S_SQR) begin
            r_acc <= r_acc + r_prod;
        end
        if (out_load) begin
            r_event   <= n_event;
            r_overlap <= r_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_overlap, r_event};

endmodule

`default_nettype wire
